[hw/rtl/bctd_pkg.sv]
`timescale 1ns / 1ps
package bctd_pkg;

    // block formats
    localparam logic [2:0] FMT_DXT1  = 3'd0;
    localparam logic [2:0] FMT_DXT3  = 3'd1;
    localparam logic [2:0] FMT_DXT5  = 3'd2;
    localparam logic [2:0] FMT_LATC1 = 3'd3;
    localparam logic [2:0] FMT_LATC2 = 3'd4;

    // largest block edge in texels
    localparam logic [2:0] DIM_MAX = 3'd4;

    // entries of the descriptor queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // one compressed block as it arrives
    typedef struct packed {
        logic [63:0] first_word;
        logic [63:0] second_word;
        logic [2:0]  valid_width;
        logic [2:0]  valid_height;
    } bctd_in_t;

    // one decoded texel
    typedef struct packed {
        logic [1:0] texel_col;
        logic [1:0] texel_row;
        logic [7:0] chan_red;
        logic [7:0] chan_green;
        logic [7:0] chan_blue;
        logic [7:0] chan_alpha;
        logic       last_texel;
    } bctd_out_t;

    // block with its palettes resolved, ready for texel lookup
    typedef struct packed {
        logic [2:0]             fmt;
        logic [2:0]             width;
        logic [2:0]             height;
        logic [3:0][2:0][7:0]   col_pal;   // [entry][r,g,b]
        logic [31:0]            col_idx;
        logic [1:0][7:0][7:0]   ramp_pal;  // [0] from first word, [1] from second word
        logic [1:0][47:0]       ramp_idx;
        logic [63:0]            alpha4;
    } bctd_desc_t;

    // rgb565 widened by a plain shift, [0] red, [1] green, [2] blue
    function automatic logic [2:0][7:0] rgb565(input logic [15:0] c);
        logic [2:0][7:0] e;
        e[0] = {c[15:11], 3'b000};
        e[1] = {c[10:5], 2'b00};
        e[2] = {c[4:0], 3'b000};
        return e;
    endfunction

    // clamp a block edge to 4
    function automatic logic [2:0] sat_dim(input logic [2:0] d);
        return (d > DIM_MAX) ? DIM_MAX : d;
    endfunction

    // floor(x / 3) for x up to 766, reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    // floor(x / 5) for x up to 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd6554;
        return p[22:15];
    endfunction

    // floor(x / 7) for x up to 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = {13'd0, x} * 24'd4682;
        return p[22:15];
    endfunction

endpackage

[hw/rtl/bc_texture_block_decoder_top.sv]
`timescale 1ns / 1ps
// Decodes one 4x4 DXT1, DXT3, DXT5, LATC1 or LATC2 block per transaction on blk and returns
// its texels on texel one per transaction, row-major over the clipped area, with last_texel on
// the final one. The format comes from cfg_data; the user must write it with cfg_we only while
// no block is in flight, and the block itself does not enforce this. In the front a block is
// loaded, its numerators are summed and its palettes divided, and it then waits in a two-entry
// queue; the front takes a new block only after handing the last one to the queue. The back
// emits one texel per cycle while pop takes them. A block with zero width or height is taken and
// yields no texels. A texel passes the payload, numerator, queue and output registers in turn.
module bc_texture_block_decoder_top import bctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  bctd_in_t   blk,
    output logic       empty,
    input  logic       pop,
    output bctd_out_t  texel,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data
);

    logic [2:0] fmt_reg;
    logic       q_wr, q_full, q_valid, q_rd;
    bctd_desc_t q_wdata, q_rdata;

    // format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_DXT1;
        else if (cfg_we)
            fmt_reg <= cfg_data;
    end

    bctd_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .blk    (blk),
        .fmt    (fmt_reg),
        .q_wr   (q_wr),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    bctd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .valid   (q_valid),
        .rd_data (q_rdata),
        .rd      (q_rd)
    );

    bctd_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rdata),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .texel   (texel)
    );

endmodule

[hw/rtl/bctd_front.sv]
`timescale 1ns / 1ps
module bctd_front import bctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  bctd_in_t   blk,
    input  logic [2:0] fmt,
    output logic       q_wr,
    output bctd_desc_t q_data,
    input  logic       q_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SUM  = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [63:0] w0_reg, w1_reg;
    logic [2:0]  fmt_reg, vw_reg, vh_reg;
    logic        four_reg, four_next;
    logic [1:0][2:0][9:0]  cn_reg, cn_next;   // colour entries 2 and 3 numerators
    logic [1:0][5:0][10:0] r8_reg, r8_next;   // eight-value ramp, entries 2..7
    logic [1:0][3:0][10:0] r6_reg, r6_next;   // six-value ramp, entries 2..5

    logic [2:0]  vw_sat, vh_sat;
    logic        take;
    logic [63:0] colw;
    logic [2:0][7:0] e0, e1;
    logic [1:0][7:0] a0, a1;

    assign vw_sat = sat_dim(blk.valid_width);
    assign vh_sat = sat_dim(blk.valid_height);
    assign full   = (state_reg != F_IDLE);
    assign take   = push && !full;

    // operands common to both compute phases
    always_comb
    begin
        colw = (fmt_reg == FMT_DXT1) ? w0_reg : w1_reg;
        e0   = rgb565(colw[15:0]);
        e1   = rgb565(colw[31:16]);
        a0[0] = w0_reg[7:0];
        a1[0] = w0_reg[15:8];
        a0[1] = w1_reg[7:0];
        a1[1] = w1_reg[15:8];
    end

    // interpolation numerators
    always_comb
    begin
        four_next = (colw[15:0] > colw[31:16]) || (fmt_reg == FMT_DXT5);
        for (int ch = 0; ch < 3; ch++)
        begin
            cn_next[0][ch] = {1'b0, e0[ch], 1'b0} + {2'b00, e1[ch]} + 10'd1;
            cn_next[1][ch] = {2'b00, e0[ch]} + {1'b0, e1[ch], 1'b0} + 10'd1;
        end
        for (int b = 0; b < 2; b++)
        begin
            for (int k = 2; k < 8; k++)
                r8_next[b][k-2] = 11'(8 - k) * {3'b000, a0[b]}
                                + 11'(k - 1) * {3'b000, a1[b]};
            for (int k = 2; k < 6; k++)
                r6_next[b][k-2] = 11'(6 - k) * {3'b000, a0[b]}
                                + 11'(k - 1) * {3'b000, a1[b]};
        end
    end

    // palettes from the registered numerators
    always_comb
    begin
        q_data        = '0;
        q_data.fmt    = fmt_reg;
        q_data.width  = vw_reg;
        q_data.height = vh_reg;
        q_data.col_idx = colw[63:32];
        q_data.alpha4 = w0_reg;
        q_data.ramp_idx[0] = w0_reg[63:16];
        q_data.ramp_idx[1] = w1_reg[63:16];
        for (int ch = 0; ch < 3; ch++)
        begin
            q_data.col_pal[0][ch] = e0[ch];
            q_data.col_pal[1][ch] = e1[ch];
            if (four_reg)
            begin
                q_data.col_pal[2][ch] = div3(cn_reg[0][ch]);
                q_data.col_pal[3][ch] = div3(cn_reg[1][ch]);
            end
            else
            begin
                q_data.col_pal[2][ch] = 8'(({1'b0, e0[ch]} + {1'b0, e1[ch]} + 9'd1) >> 1);
                q_data.col_pal[3][ch] = 8'd0;
            end
        end
        for (int b = 0; b < 2; b++)
        begin
            q_data.ramp_pal[b][0] = a0[b];
            q_data.ramp_pal[b][1] = a1[b];
            for (int k = 2; k < 8; k++)
            begin
                if (a0[b] > a1[b])
                    q_data.ramp_pal[b][k] = div7(r8_reg[b][k-2]);
                else if (k < 6)
                    q_data.ramp_pal[b][k] = div5(r6_reg[b][k-2]);
                else if (k == 6)
                    q_data.ramp_pal[b][k] = 8'd0;
                else
                    q_data.ramp_pal[b][k] = 8'd255;
            end
        end
    end

    // sequencer: load, sum, divide and hand over
    always_comb
    begin
        state_next = state_reg;
        q_wr       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (take && vw_sat != 3'd0 && vh_sat != 3'd0)
                    state_next = F_SUM;
            end
            F_SUM:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (!q_full)
                begin
                    q_wr       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // block payload and numerators
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            w0_reg  <= blk.first_word;
            w1_reg  <= blk.second_word;
            fmt_reg <= fmt;
            vw_reg  <= vw_sat;
            vh_reg  <= vh_sat;
        end
        if (state_reg == F_SUM)
        begin
            four_reg <= four_next;
            cn_reg   <= cn_next;
            r8_reg   <= r8_next;
            r6_reg   <= r6_next;
        end
    end

endmodule

[hw/rtl/bctd_queue.sv]
`timescale 1ns / 1ps
module bctd_queue import bctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr,
    input  bctd_desc_t wr_data,
    output logic       full,
    output logic       valid,
    output bctd_desc_t rd_data,
    input  logic       rd
);

    bctd_desc_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               do_wr, do_rd;

    assign full    = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

[hw/rtl/bctd_back.sv]
`timescale 1ns / 1ps
module bctd_back import bctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  bctd_desc_t q_data,
    output logic       q_rd,
    output logic       empty,
    input  logic       pop,
    output bctd_out_t  texel
);

    logic [1:0] col_reg, row_reg;
    logic       out_valid_reg;
    bctd_out_t  out_reg, tx;
    logic       out_ready, advance;
    logic       col_end, row_end;
    logic [3:0] t;
    logic [1:0] ci;
    logic [5:0] rbase;
    logic [2:0] k0, k1;
    logic [3:0] nib;

    assign out_ready = !out_valid_reg || pop;
    assign advance   = q_valid && out_ready;
    assign col_end   = ({1'b0, col_reg} + 3'd1) == q_data.width;
    assign row_end   = ({1'b0, row_reg} + 3'd1) == q_data.height;
    assign q_rd      = advance && col_end && row_end;
    assign empty     = !out_valid_reg;
    assign texel     = out_reg;

    // texel lookup
    always_comb
    begin
        t     = {row_reg, col_reg};
        ci    = q_data.col_idx[{t, 1'b0} +: 2];
        rbase = {2'b00, t} + {1'b0, t, 1'b0};
        k0    = q_data.ramp_idx[0][rbase +: 3];
        k1    = q_data.ramp_idx[1][rbase +: 3];
        nib   = q_data.alpha4[{t, 2'b00} +: 4];

        tx            = '0;
        tx.texel_col  = col_reg;
        tx.texel_row  = row_reg;
        tx.last_texel = col_end && row_end;
        case (q_data.fmt)
            FMT_DXT1:
            begin
                tx.chan_red   = q_data.col_pal[ci][0];
                tx.chan_green = q_data.col_pal[ci][1];
                tx.chan_blue  = q_data.col_pal[ci][2];
            end
            FMT_DXT3:
            begin
                tx.chan_red   = q_data.col_pal[ci][0];
                tx.chan_green = q_data.col_pal[ci][1];
                tx.chan_blue  = q_data.col_pal[ci][2];
                tx.chan_alpha = {nib, nib};
            end
            FMT_DXT5:
            begin
                tx.chan_red   = q_data.col_pal[ci][0];
                tx.chan_green = q_data.col_pal[ci][1];
                tx.chan_blue  = q_data.col_pal[ci][2];
                tx.chan_alpha = q_data.ramp_pal[0][k0];
            end
            FMT_LATC1:
            begin
                tx.chan_red = q_data.ramp_pal[0][k0];
            end
            FMT_LATC2:
            begin
                tx.chan_red   = q_data.ramp_pal[1][k1];
                tx.chan_green = q_data.ramp_pal[0][k0];
            end
            default:
            begin
                tx.chan_red = 8'd0;
            end
        endcase
    end

    // texel walk and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? 2'd0 : row_reg + 2'd1;
                end
                else
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= tx;
    end

endmodule

[hw/rtl/bctd_checker.sv]
`timescale 1ns / 1ps
module bctd_checker import bctd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      empty,
    input logic      pop,
    input bctd_out_t texel
);

    // nothing waits at the output while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // a waiting texel holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(texel)))
        else $error("waiting texel changed or vanished");

    // after the last texel of a block the next one starts at the origin
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && texel.last_texel) |=>
        (empty || (texel.texel_col == 2'd0 && texel.texel_row == 2'd0)))
        else $error("block did not start at the first texel");

    // within a block texels follow without a gap in row-major order
    a_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !texel.last_texel) |=>
        (!empty &&
         ((texel.texel_col == 2'($past(texel.texel_col) + 2'd1) &&
           texel.texel_row == $past(texel.texel_row)) ||
          (texel.texel_col == 2'd0 &&
           texel.texel_row == 2'($past(texel.texel_row) + 2'd1)))))
        else $error("texel order broken inside a block");

endmodule

bind bc_texture_block_decoder_top bctd_checker u_bctd_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .texel (texel)
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import bctd_pkg::*;

    // format codes the decoder treats as unknown
    localparam logic [2:0] FMT_RSVD_5 = 3'd5;
    localparam logic [2:0] FMT_RSVD_6 = 3'd6;
    localparam logic [2:0] FMT_RSVD_7 = 3'd7;

    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int          N_DIRECTED   = 24;
    localparam int          N_PHASES     = 10;
    localparam int          PHASE_BLOCKS = 25;

    // one directed block, with its channels typed in where they are obvious
    typedef struct packed {
        logic [2:0]  fmt;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [2:0]  vw;
        logic [2:0]  vh;
        logic        fixed;
        logic [31:0] rgba;
    } stim_row_t;

    logic       clk;
    logic       rst_n    = 1'b1;
    logic       push     = 1'b0;
    logic       full;
    bctd_in_t   blk      = '0;
    logic       empty;
    logic       pop      = 1'b0;
    bctd_out_t  texel;
    logic       cfg_we   = 1'b0;
    logic [2:0] cfg_data = '0;

    // texels still owed by the decoder, oldest first
    bctd_out_t   texels_due[$];
    logic [2:0]  fmt_now = FMT_DXT1;
    int unsigned bad_texels = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    stim_row_t   dir_rows [0:N_DIRECTED-1];

    bc_texture_block_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .blk      (blk),
        .empty    (empty),
        .pop      (pop),
        .texel    (texel),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // rgb565 palette entry, four-colour ramp when c0 > c1 or forced
    function automatic logic [2:0][7:0] palette_colour(input logic [63:0] word,
                                                       input bit force4,
                                                       input logic [1:0] sel);
        logic [15:0]     c0;
        logic [15:0]     c1;
        int unsigned     e0 [3];
        int unsigned     e1 [3];
        int unsigned     v;
        logic [2:0][7:0] rgb;
        c0 = word[15:0];
        c1 = word[31:16];
        e0[0] = {24'd0, c0[15:11], 3'b000};
        e0[1] = {24'd0, c0[10:5], 2'b00};
        e0[2] = {24'd0, c0[4:0], 3'b000};
        e1[0] = {24'd0, c1[15:11], 3'b000};
        e1[1] = {24'd0, c1[10:5], 2'b00};
        e1[2] = {24'd0, c1[4:0], 3'b000};
        for (int i = 0; i < 3; i++)
        begin
            if (sel == 2'd0)
                v = e0[i];
            else if (sel == 2'd1)
                v = e1[i];
            else if (c0 > c1 || force4)
                v = (sel == 2'd2) ? (2 * e0[i] + e1[i] + 1) / 3 : (e0[i] + 2 * e1[i] + 1) / 3;
            else
                v = (sel == 2'd2) ? (e0[i] + e1[i] + 1) >> 1 : 0;
            rgb[i] = 8'(v);
        end
        return rgb;
    endfunction

    // 8-value or 6-value scalar ramp for texel n of the block
    function automatic logic [7:0] ramp_level(input logic [63:0] word, input int n);
        int unsigned a0;
        int unsigned a1;
        int unsigned k;
        a0 = word[7:0];
        a1 = word[15:8];
        k  = 32'(3'(word >> (16 + 3 * n)));
        if (k == 0)
            return 8'(a0);
        if (k == 1)
            return 8'(a1);
        if (a0 > a1)
            return 8'(((8 - k) * a0 + (k - 1) * a1) / 7);
        if (k >= 6)
            return (k == 6) ? 8'd0 : 8'd255;
        return 8'(((6 - k) * a0 + (k - 1) * a1) / 5);
    endfunction

    // queue the texels one block transaction should produce
    task automatic queue_block(input bctd_in_t b, input logic [2:0] fmt,
                               input logic fixed, input logic [31:0] rgba);
        logic [2:0]      w;
        logic [2:0]      h;
        int              n;
        logic [2:0][7:0] rgb;
        bctd_out_t       t;
        w = (b.valid_width > DIM_MAX) ? DIM_MAX : b.valid_width;
        h = (b.valid_height > DIM_MAX) ? DIM_MAX : b.valid_height;
        for (int row = 0; row < h; row++)
        begin
            for (int col = 0; col < w; col++)
            begin
                n = 4 * row + col;
                t = '0;
                t.texel_col  = 2'(col);
                t.texel_row  = 2'(row);
                t.last_texel = (row + 1 == h && col + 1 == w);
                case (fmt)
                    FMT_DXT1:
                    begin
                        rgb = palette_colour(b.first_word, 1'b0, 2'(b.first_word >> (32 + 2 * n)));
                        {t.chan_red, t.chan_green, t.chan_blue} = {rgb[0], rgb[1], rgb[2]};
                    end
                    FMT_DXT3:
                    begin
                        rgb = palette_colour(b.second_word, 1'b0,
                                             2'(b.second_word >> (32 + 2 * n)));
                        {t.chan_red, t.chan_green, t.chan_blue} = {rgb[0], rgb[1], rgb[2]};
                        t.chan_alpha = 8'(4'(b.first_word >> (4 * n)) * 17);
                    end
                    FMT_DXT5:
                    begin
                        rgb = palette_colour(b.second_word, 1'b1,
                                             2'(b.second_word >> (32 + 2 * n)));
                        {t.chan_red, t.chan_green, t.chan_blue} = {rgb[0], rgb[1], rgb[2]};
                        t.chan_alpha = ramp_level(b.first_word, n);
                    end
                    FMT_LATC1:
                        t.chan_red = ramp_level(b.first_word, n);
                    FMT_LATC2:
                    begin
                        t.chan_red   = ramp_level(b.second_word, n);
                        t.chan_green = ramp_level(b.first_word, n);
                    end
                    default:
                        ;
                endcase
                if (fixed)
                    {t.chan_red, t.chan_green, t.chan_blue, t.chan_alpha} = rgba;
                texels_due.push_back(t);
            end
        end
    endtask

    // offer one block, with an optional gap first, and wait for the transaction
    task automatic offer_block(input bctd_in_t b, input logic fixed, input logic [31:0] rgba);
        if (!calm && $urandom_range(99) < 23)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        blk  <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        queue_block(b, fmt_now, fixed, rgba);
    endtask

    // drain every owed texel and let zero-sized blocks clear the pipeline
    task automatic settle();
        push <= 1'b0;
        while (texels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_format(input logic [2:0] f);
        cfg_we   <= 1'b1;
        cfg_data <= f;
        @(posedge clk);
        cfg_we   <= 1'b0;
        fmt_now  = f;
    endtask

    // stimulus: directed table, then random phases
    initial
    begin
        bctd_in_t   b;
        logic [2:0] phase_fmt [N_PHASES];
        int unsigned pick;
        dir_rows = '{
            '{FMT_DXT1, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'h0000_0000},
            '{FMT_DXT1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd4, 3'd4, 1'b1,
              32'h0000_0000},
            '{FMT_DXT1, 64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'hF8FC_F800},
            '{FMT_DXT1, 64'hFFFF_FFFF_0000_FFFF, 64'h0, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_DXT1, 64'hAAAA_AAAA_FFFF_0000, 64'h0, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_DXT1, 64'h1B3F_92C4_5E07_A86D, 64'h0, 3'd0, 3'd4, 1'b0, 32'h0},
            '{FMT_DXT1, 64'hC6A1_0F3E_77D2_19B8, 64'h0, 3'd4, 3'd0, 1'b0, 32'h0},
            '{FMT_DXT1, 64'h5D2E_E817_3C40_9AF1, 64'h8E3C_1F00_2B7A_D665, 3'd7, 3'd5, 1'b0, 32'h0},
            '{FMT_DXT1, 64'h0123_4567_89AB_CDEF, 64'h0, 3'd1, 3'd1, 1'b0, 32'h0},
            '{FMT_DXT1, 64'hE4E4_1B1B_7BEF_0841, 64'h0, 3'd3, 3'd2, 1'b0, 32'h0},
            '{FMT_DXT3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'h0000_00FF},
            '{FMT_DXT3, 64'h0, 64'h9C3A_57E1_4410_B2D8, 3'd2, 3'd3, 1'b0, 32'h0},
            '{FMT_DXT3, 64'h7F30_C2A9_05BE_E1D4, 64'hD8E4_271B_6A35_6A35, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_DXT5, 64'h0000_0000_0000_00FF, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'h0000_00FF},
            '{FMT_DXT5, 64'h6DB6_DB49_2492_C80A, 64'h39C6_E4B1_F800_001F, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_DXT5, 64'hFFFF_FFFF_FFFF_0000, 64'h5A5A_A5A5_3333_CCCC, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_LATC1, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd4, 3'd4, 1'b1,
              32'hFF00_0000},
            '{FMT_LATC1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'hFF00_0000},
            '{FMT_LATC1, 64'hFAC6_88D1_53B9_40C0, 64'h0, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_LATC2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 3'd4, 3'd4, 1'b1,
              32'h00FF_0000},
            '{FMT_LATC2, 64'h2DB4_6E91_A70F_10F0, 64'hB392_04CE_58A1_FF01, 3'd4, 3'd4, 1'b0, 32'h0},
            '{FMT_RSVD_7, 64'hA5C3_9E01_7F42_B8D6, 64'h3C5A_E71D_0B96_F248, 3'd4, 3'd4, 1'b1,
              32'h0000_0000},
            '{FMT_RSVD_5, 64'h4E8B_21F7_C03D_96AA, 64'hF1E2_D3C4_B5A6_9788, 3'd3, 3'd4, 1'b1,
              32'h0000_0000},
            '{FMT_RSVD_6, 64'h9B7D_5F31_E2C4_A608, 64'h1357_9BDF_2468_ACE0, 3'd6, 3'd4, 1'b1,
              32'h0000_0000}
        };
        phase_fmt = '{FMT_DXT5, FMT_DXT1, FMT_LATC2, FMT_DXT3, FMT_RSVD_7,
                      FMT_LATC1, FMT_DXT5, FMT_DXT1, FMT_DXT1, FMT_DXT1};
        phase_fmt[8] = 3'($urandom_range(7));
        phase_fmt[9] = 3'($urandom_range(7));

        // reset from a clean falling edge ahead of the first clock
        #1 rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed blocks, grouped by format, first ones at the reset format
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (dir_rows[i].fmt != fmt_now)
            begin
                settle();
                write_format(dir_rows[i].fmt);
            end
            b.first_word   = dir_rows[i].w0;
            b.second_word  = dir_rows[i].w1;
            b.valid_width  = dir_rows[i].vw;
            b.valid_height = dir_rows[i].vh;
            offer_block(b, dir_rows[i].fixed, dir_rows[i].rgba);
        end

        // random phases, one format each
        for (int p = 0; p < N_PHASES; p++)
        begin
            settle();
            write_format(phase_fmt[p]);
            calm = (p == 3);
            if (p == 1)
                hold_req = 1'b1;
            for (int j = 0; j < PHASE_BLOCKS; j++)
            begin
                b.first_word  = {$urandom, $urandom};
                b.second_word = {$urandom, $urandom};
                // equal endpoints reach the three-colour and 6-value ramps
                if ($urandom_range(7) == 0)
                    b.first_word[31:16] = b.first_word[15:0];
                if ($urandom_range(7) == 0)
                    b.second_word[31:16] = b.second_word[15:0];
                if ($urandom_range(7) == 0)
                    b.first_word[15:8] = b.first_word[7:0];
                if ($urandom_range(7) == 0)
                    b.second_word[15:8] = b.second_word[7:0];
                b.valid_width  = 3'($urandom_range(1, 4));
                b.valid_height = 3'($urandom_range(1, 4));
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    if ($urandom_range(1) == 0)
                        b.valid_width = 3'd0;
                    else
                        b.valid_height = 3'd0;
                end
                else if (pick < 15)
                begin
                    b.valid_width  = 3'($urandom_range(5, 7));
                    b.valid_height = 3'($urandom_range(1, 7));
                end
                offer_block(b, 1'b0, 32'h0);
            end
        end
        calm = 1'b0;

        // drain and report
        push <= 1'b0;
        while (texels_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (bad_texels == 0 && texels_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // texel side: check each transaction, idle and hold off at random
    initial
    begin
        bctd_out_t   want;
        int unsigned hold_cnt;
        hold_cnt = 0;
        wait (!rst_n);
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (texels_due.size() == 0)
                begin
                    if (bad_texels < 10)
                        $display("unexpected texel: col %0d row %0d rgba %02h %02h %02h %02h",
                                 texel.texel_col, texel.texel_row, texel.chan_red,
                                 texel.chan_green, texel.chan_blue, texel.chan_alpha);
                    bad_texels++;
                end
                else
                begin
                    want = texels_due.pop_front();
                    if (texel !== want)
                    begin
                        if (bad_texels < 10)
                        begin
                            $write("texel mismatch: expected col %0d row %0d",
                                   want.texel_col, want.texel_row);
                            $write(" rgba %02h %02h %02h %02h last %0b,",
                                   want.chan_red, want.chan_green, want.chan_blue,
                                   want.chan_alpha, want.last_texel);
                            $write(" got col %0d row %0d", texel.texel_col, texel.texel_row);
                            $display(" rgba %02h %02h %02h %02h last %0b",
                                     texel.chan_red, texel.chan_green, texel.chan_blue,
                                     texel.chan_alpha, texel.last_texel);
                        end
                        bad_texels++;
                    end
                end
            end
            if (hold_req && hold_cnt < HOLD_CYCLES)
            begin
                hold_cnt++;
                pop <= 1'b0;
            end
            else if (calm)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(99) >= 23);
        end
    end

    // watchdog on cycles with no transaction on either side
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
